FILE: sv/sihit_pkg.sv
// Shared types, constants and hash function for the string hash intern table.
package sihit_pkg;

    localparam int POOL_NODES   = 2048;
    localparam int BUCKET_COUNT = 32;   // power of two
    localparam int QUEUE_DEPTH  = 2;

    localparam int IDX_W  = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int CNT_W  = $clog2(POOL_NODES + 2);
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] HASH_SEED = 32'h09B6_6E03;
    localparam logic [31:0] HASH_MUL  = 32'h09B6_6C41;
    localparam logic [31:0] HASH_XOR  = 32'h1DE1_3C89;
    localparam logic [31:0] HASH_ODD  = 32'h8000_0001;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic        empty;
        logic [31:0] hash;
    } q_entry_t;

    typedef struct packed {
        logic [31:0]       key;
        logic [LINK_W-1:0] less;
        logic [LINK_W-1:0] more;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    function automatic logic [31:0] fold_char(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] sum;
        logic [31:0] prod;
        sum  = h + {{24{c[7]}}, c};
        prod = sum * HASH_MUL;
        return prod ^ HASH_XOR;
    endfunction

endpackage

FILE: sv/string_hash_intern_table_unit.sv
// Top level of the string hash intern table.
//
//  channel  | handshake         | word
//  ---------+-------------------+-----------------------------
//  input    | start, busy       | ch, last
//  result   | done (strobe)     | hash, status, overflow_first
//
// A character is hashed in the cycle it is taken; busy rises only when the
// two-entry name queue is full.
// A name's lookup finishes from the idle state for an empty name, a full pool or
// an empty bucket; otherwise it visits one tree node per step until found, and
// an insertion adds a final write state, bounded by the single node RAM port.
// Reset clears bucket roots and the node count; no clearing pass.
// Results cannot be held off; done is high for one cycle per name.
module string_hash_intern_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        done,
    output logic [31:0] hash,
    output logic [1:0]  status,
    output logic        overflow_first
);

    logic                q_push, q_pop, q_empty, q_full;
    sihit_pkg::q_entry_t q_in, q_head;

    assign busy = q_full;

    sihit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .ch        (ch),
        .last      (last),
        .push      (q_push),
        .push_word (q_in)
    );

    sihit_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    sihit_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_empty        (q_empty),
        .pop            (q_pop),
        .done           (done),
        .hash           (hash),
        .status         (status),
        .overflow_first (overflow_first)
    );

endmodule

FILE: sv/sihit_ram.sv
// Generic single-port RAM with registered read.
module sihit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/sihit_front.sv
// Front end: folds characters into the rolling hash and emits finished names.
module sihit_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         ch,
    input  logic               last,
    output logic               push,
    output sihit_pkg::q_entry_t push_word
);

    logic [31:0] run_reg, run_next;
    logic        in_name_reg, in_name_next;
    logic [31:0] folded;

    always_comb
    begin
        folded       = sihit_pkg::fold_char(run_reg, ch);
        run_next     = run_reg;
        in_name_next = in_name_reg;
        push         = 1'b0;
        push_word    = '0;
        if (accept)
        begin
            if (!in_name_reg && ch == 8'd0)
            begin
                push            = 1'b1;
                push_word.empty = 1'b1;
                run_next        = sihit_pkg::HASH_SEED;
            end
            else if (last)
            begin
                push           = 1'b1;
                push_word.hash = folded[0] ? folded : (folded ^ sihit_pkg::HASH_ODD);
                run_next       = sihit_pkg::HASH_SEED;
                in_name_next   = 1'b0;
            end
            else
            begin
                run_next     = folded;
                in_name_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= sihit_pkg::HASH_SEED;
            in_name_reg <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            in_name_reg <= in_name_next;
        end
    end

endmodule

FILE: sv/sihit_queue.sv
// Short FIFO of finished names between front and back.
module sihit_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sihit_pkg::q_entry_t push_word,
    input  logic                pop,
    output sihit_pkg::q_entry_t head,
    output logic                empty,
    output logic                full
);

    sihit_pkg::q_entry_t entry_reg [sihit_pkg::QUEUE_DEPTH];
    logic [sihit_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [sihit_pkg::QCNT_W-1:0] cnt_reg;

    assign head  = entry_reg[rd_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == sihit_pkg::QCNT_W'(sihit_pkg::QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == sihit_pkg::QPTR_W'(sihit_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == sihit_pkg::QPTR_W'(sihit_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/sihit_back.sv
// Back end: bucket lookup, tree walk and node insertion.
module sihit_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sihit_pkg::q_entry_t head,
    input  logic                q_empty,
    output logic                pop,
    output logic                done,
    output logic [31:0]         hash,
    output logic [1:0]          status,
    output logic                overflow_first
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [31:0] key_reg, key_next;
    logic [sihit_pkg::IDX_W-1:0] cur_reg, cur_next;
    logic [sihit_pkg::CNT_W-1:0] used_reg, used_next;
    logic [sihit_pkg::LINK_W-1:0] root_reg [sihit_pkg::BUCKET_COUNT];
    logic [sihit_pkg::LINK_W-1:0] root_next [sihit_pkg::BUCKET_COUNT];

    logic        done_reg, done_next;
    logic [31:0] hash_reg, hash_next;
    logic [1:0]  status_reg, status_next;
    logic        first_reg, first_next;

    logic                          ram_we;
    logic [sihit_pkg::IDX_W-1:0]   ram_addr;
    logic [sihit_pkg::NODE_W-1:0]  ram_wdata, ram_rdata;
    sihit_pkg::node_t              node, upd;
    logic [sihit_pkg::BKT_W-1:0]   bkt;
    logic [sihit_pkg::LINK_W-1:0]  link, new_link;
    logic [sihit_pkg::IDX_W-1:0]   new_idx;

    sihit_ram #(
        .WIDTH (sihit_pkg::NODE_W),
        .DEPTH (sihit_pkg::POOL_NODES)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign done           = done_reg;
    assign hash           = hash_reg;
    assign status         = status_reg;
    assign overflow_first = first_reg;

    always_comb
    begin
        node       = sihit_pkg::node_t'(ram_rdata);
        upd        = node;
        new_idx    = used_reg[sihit_pkg::IDX_W-1:0];
        new_link   = sihit_pkg::LINK_W'(used_reg + 1'b1);
        bkt        = head.hash[sihit_pkg::BKT_W:1];
        link       = root_reg[bkt];
        state_next = state_reg;
        key_next   = key_reg;
        cur_next   = cur_reg;
        used_next  = used_reg;
        root_next  = root_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cur_reg;
        ram_wdata  = '0;
        done_next  = 1'b0;
        hash_next  = hash_reg;
        status_next = status_reg;
        first_next = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (head.empty)
                    begin
                        done_next   = 1'b1;
                        hash_next   = '0;
                        status_next = sihit_pkg::ST_EMPTY;
                        first_next  = 1'b0;
                    end
                    else if (used_reg >= sihit_pkg::CNT_W'(sihit_pkg::POOL_NODES))
                    begin
                        done_next   = 1'b1;
                        hash_next   = head.hash;
                        status_next = sihit_pkg::ST_FULL;
                        first_next  = (used_reg == sihit_pkg::CNT_W'(sihit_pkg::POOL_NODES));
                        if (first_next)
                        begin
                            used_next = used_reg + 1'b1;
                        end
                    end
                    else if (link == '0)
                    begin
                        ram_we          = 1'b1;
                        ram_addr        = new_idx;
                        ram_wdata       = {head.hash, {(2 * sihit_pkg::LINK_W){1'b0}}};
                        root_next[bkt]  = new_link;
                        used_next       = used_reg + 1'b1;
                        done_next       = 1'b1;
                        hash_next       = head.hash;
                        status_next     = sihit_pkg::ST_NEW;
                        first_next      = 1'b0;
                    end
                    else
                    begin
                        ram_addr   = sihit_pkg::IDX_W'(link - 1'b1);
                        cur_next   = ram_addr;
                        key_next   = head.hash;
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                if (key_reg == node.key)
                begin
                    done_next   = 1'b1;
                    hash_next   = key_reg;
                    status_next = sihit_pkg::ST_PRESENT;
                    first_next  = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    link = (key_reg < node.key) ? node.less : node.more;
                    if (link == '0)
                    begin
                        if (key_reg < node.key)
                        begin
                            upd.less = new_link;
                        end
                        else
                        begin
                            upd.more = new_link;
                        end
                        ram_we     = 1'b1;
                        ram_wdata  = upd;
                        state_next = S_INS;
                    end
                    else
                    begin
                        ram_addr = sihit_pkg::IDX_W'(link - 1'b1);
                        cur_next = ram_addr;
                    end
                end
            end
            S_INS:
            begin
                ram_we      = 1'b1;
                ram_addr    = new_idx;
                ram_wdata   = {key_reg, {(2 * sihit_pkg::LINK_W){1'b0}}};
                used_next   = used_reg + 1'b1;
                done_next   = 1'b1;
                hash_next   = key_reg;
                status_next = sihit_pkg::ST_NEW;
                first_next  = 1'b0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        hash_reg   <= hash_next;
        status_reg <= status_next;
        first_reg  <= first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < sihit_pkg::BUCKET_COUNT; i++)
            begin
                root_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            root_reg  <= root_next;
        end
    end

endmodule

FILE: sv/sihit_checker.sv
// Port-level checks for the string hash intern table, bound to the top level.
module sihit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [31:0] hash,
    input logic [1:0]  status,
    input logic        overflow_first
);

    logic seen_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_ovf_reg <= 1'b0;
        end
        else if (done && overflow_first)
        begin
            seen_ovf_reg <= 1'b1;
        end
    end

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == sihit_pkg::ST_EMPTY) == (hash == 32'd0)))
        else $error("empty-name status and zero hash disagree");

    a_hash_odd: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != sihit_pkg::ST_EMPTY |-> hash[0])
        else $error("name hash is even");

    a_first_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow_first |-> status == sihit_pkg::ST_FULL && !seen_ovf_reg)
        else $error("overflow flagged twice or without pool full");

    a_full_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == sihit_pkg::ST_FULL && !overflow_first |-> seen_ovf_reg)
        else $error("pool full without a first overflow");

    a_no_new_after_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && seen_ovf_reg |-> status != sihit_pkg::ST_NEW)
        else $error("insert after pool full");

endmodule

bind string_hash_intern_table_unit sihit_checker u_sihit_checker (.*);

FILE: test/tb_string_hash_intern_table_unit.sv
// Self-checking testbench for the string hash intern table unit.
`timescale 1ns / 100ps

module tb_string_hash_intern_table_unit;

    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_PRINTED  = 100;

    class intern_scoreboard;

        typedef struct {
            logic [31:0] hash;
            logic [1:0]  status;
            logic        first;
        } name_result_t;

        logic [31:0]                  name_hash;
        bit                           mid_name;
        logic [sihit_pkg::LINK_W-1:0] root_link [sihit_pkg::BUCKET_COUNT];
        logic [31:0]                  node_hash [sihit_pkg::POOL_NODES];
        logic [sihit_pkg::LINK_W-1:0] less_link [sihit_pkg::POOL_NODES];
        logic [sihit_pkg::LINK_W-1:0] more_link [sihit_pkg::POOL_NODES];
        int unsigned                  nodes_used;
        name_result_t                 expected_results [$];
        int                           errors;

        function new();
            name_hash  = sihit_pkg::HASH_SEED;
            mid_name   = 1'b0;
            nodes_used = 0;
            errors     = 0;
            foreach (root_link[i])
                root_link[i] = '0;
        endfunction

        function automatic logic [31:0] mix_char(input logic [31:0] h, input logic [7:0] c);
            logic [31:0] widened;
            logic [31:0] product;
            widened = {{24{c[7]}}, c};
            product = (h + widened) * sihit_pkg::HASH_MUL;
            return product ^ sihit_pkg::HASH_XOR;
        endfunction

        // walks the bucket tree; inserts when the key is new and the pool has room
        function automatic logic [1:0] intern_hash(input logic [31:0] h, output logic first);
            int          bucket;
            int          parent;
            int          idx;
            int          steps;
            bit          go_less;
            logic [sihit_pkg::LINK_W-1:0] cur;
            first = 1'b0;
            if (nodes_used < sihit_pkg::POOL_NODES) begin
                bucket  = (h >> 1) % sihit_pkg::BUCKET_COUNT;
                cur     = root_link[bucket];
                parent  = -1;
                go_less = 1'b0;
                steps   = 0;
                while (cur != 0 && steps < sihit_pkg::POOL_NODES) begin
                    idx = cur - 1;
                    if (h == node_hash[idx])
                        return sihit_pkg::ST_PRESENT;
                    parent  = idx;
                    go_less = h < node_hash[idx];
                    cur     = go_less ? less_link[idx] : more_link[idx];
                    steps++;
                end
                node_hash[nodes_used] = h;
                less_link[nodes_used] = '0;
                more_link[nodes_used] = '0;
                if (parent < 0)
                    root_link[bucket] = sihit_pkg::LINK_W'(nodes_used + 1);
                else if (go_less)
                    less_link[parent] = sihit_pkg::LINK_W'(nodes_used + 1);
                else
                    more_link[parent] = sihit_pkg::LINK_W'(nodes_used + 1);
                nodes_used++;
                return sihit_pkg::ST_NEW;
            end
            if (nodes_used == sihit_pkg::POOL_NODES) begin
                first = 1'b1;
                nodes_used++;
            end
            return sihit_pkg::ST_FULL;
        endfunction

        function void note_word(input logic [7:0] c, input logic l);
            name_result_t res;
            logic [31:0]  h;
            if (!mid_name && c == 8'h00) begin
                name_hash  = sihit_pkg::HASH_SEED;
                res.hash   = '0;
                res.status = sihit_pkg::ST_EMPTY;
                res.first  = 1'b0;
                expected_results.push_back(res);
                return;
            end
            name_hash = mix_char(name_hash, c);
            mid_name  = 1'b1;
            if (!l)
                return;
            h = name_hash;
            if (!h[0])
                h = h ^ sihit_pkg::HASH_ODD;
            res.hash   = h;
            res.status = intern_hash(h, res.first);
            name_hash  = sihit_pkg::HASH_SEED;
            mid_name   = 1'b0;
            expected_results.push_back(res);
        endfunction

        function void report(input string msg);
            if (errors < MAX_PRINTED)
                $display("%0t ERROR: %s", $time, msg);
            errors++;
        endfunction

        function void check_result(input logic [31:0] h, input logic [1:0] s, input logic f);
            name_result_t exp_res;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result hash=%h status=%0d", h, s));
                return;
            end
            exp_res = expected_results.pop_front();
            if (h !== exp_res.hash)
                report($sformatf("hash %h, expected %h", h, exp_res.hash));
            if (s !== exp_res.status)
                report($sformatf("status %0d, expected %0d (hash %h)", s, exp_res.status,
                                 exp_res.hash));
            if (f !== exp_res.first)
                report($sformatf("overflow_first %b, expected %b (hash %h)", f,
                                 exp_res.first, exp_res.hash));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void flush_missing();
            name_result_t exp_res;
            while (expected_results.size() > 0) begin
                exp_res = expected_results.pop_front();
                report($sformatf("missing result for hash %h", exp_res.hash));
            end
        endfunction

    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  ch = 8'h00;
    logic        last = 1'b0;
    logic        done;
    logic [31:0] hash;
    logic [1:0]  status;
    logic        overflow_first;

    intern_scoreboard table_model = new();

    logic [47:0] known_names [$];
    int          known_lens [$];
    int          words_sent = 0;
    bit          no_idle = 1'b0;
    int          cycles = 0;

    string_hash_intern_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .ch             (ch),
        .last           (last),
        .done           (done),
        .hash           (hash),
        .status         (status),
        .overflow_first (overflow_first)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done === 1'b1)
                table_model.check_result(hash, status, overflow_first);
            if (start && busy === 1'b0)
                table_model.note_word(ch, last);
        end
    end

    task automatic send_word(input logic [7:0] c, input logic l);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        ch    <= c;
        last  <= l;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        words_sent++;
    endtask

    task automatic send_name(input logic [47:0] bytes, input int len);
        for (int i = 0; i < len; i++)
            send_word(bytes[8*i +: 8], i == len - 1);
        if (bytes[7:0] != 8'h00) begin
            known_names.push_back(bytes);
            known_lens.push_back(len);
        end
    endtask

    task automatic send_random_name(input int max_len);
        logic [47:0] bytes;
        int          len;
        len   = $urandom_range(1, max_len);
        bytes = 48'({$urandom, $urandom});
        bytes[7:0] = 8'($urandom_range(1, 255));
        for (int i = 1; i < len; i++)
            if ($urandom_range(0, 15) == 0)
                bytes[8*i +: 8] = 8'h00;
        send_name(bytes, len);
    endtask

    task automatic send_known_name();
        int pick;
        pick = $urandom_range(0, known_names.size() - 1);
        send_name(known_names[pick], known_lens[pick]);
    endtask

    initial
    begin
        int waited;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty names, sign extremes, zero byte inside a name, repeats
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        send_name(48'hFF, 1);
        send_name(48'h80, 1);
        send_name(48'h7F, 1);
        send_name(48'h01, 1);
        send_name(48'h42_00_41, 3);
        send_name(48'hFF, 1);
        send_name(48'hFF_80, 2);
        send_name(48'h42_00_41, 3);
        send_word(8'h00, 1'b1);
        send_name(48'h00_00_00_00_00_7F, 6);
        send_name(48'hFF_FF_FF_FF_FF_FF, 6);
        send_name(48'h80, 1);

        while (words_sent < RANDOM_WORDS) begin
            int pick;
            if ($urandom_range(0, 19) == 0)
                no_idle = ~no_idle;
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_word(8'h00, 1'($urandom_range(0, 1)));
            else if (pick < 30)
                send_known_name();
            else
                send_random_name(6);
        end

        for (int i = 0; i < 20; i++) begin
            if (i % 4 == 0)
                send_word(8'h00, 1'($urandom_range(0, 1)));
            else if (i % 2 == 0)
                send_known_name();
            else
                send_random_name(3);
        end
        start <= 1'b0;

        waited = 0;
        while (table_model.pending() > 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        table_model.flush_missing();

        if (table_model.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
